@@ design/css_pkg.sv @@
// Shared types and constants of the chaser step sequencer.
// Holds the register map, operation codes, run orders and the structs passed between modules.
// Depends on nothing.
package css_pkg;

  localparam int DEFAULT_MAX_STEPS = 256;

  localparam int COUNT_W = 9;
  localparam int INDEX_W = 8;
  localparam int TICK_W  = 24;
  localparam int OP_W    = 3;
  localparam int ORDER_W = 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int REG_W   = 3;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_NEXT    = 3'd1;
  localparam logic [OP_W-1:0] OP_PREV    = 3'd2;
  localparam logic [OP_W-1:0] OP_JUMP    = 3'd3;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd4;

  localparam logic [ORDER_W-1:0] ORDER_SINGLE = 2'd0;
  localparam logic [ORDER_W-1:0] ORDER_LOOP   = 2'd1;

  localparam logic [REG_W-1:0] REG_STEP_COUNT     = 3'd0;
  localparam logic [REG_W-1:0] REG_HOLD_TICKS     = 3'd1;
  localparam logic [REG_W-1:0] REG_RUN_ORDER      = 3'd2;
  localparam logic [REG_W-1:0] REG_START_BACKWARD = 3'd3;
  localparam logic [REG_W-1:0] REG_AUTO_STEP      = 3'd4;

  typedef struct packed {
    logic [COUNT_W-1:0] step_count;
    logic [TICK_W-1:0]  hold_ticks;
    logic [ORDER_W-1:0] run_order;
    logic               start_backward;
    logic               auto_step;
  } cfg_t;

  typedef struct packed {
    logic [INDEX_W-1:0] current_step;
    logic               step_changed;
    logic               finished;
    logic               going_backward;
    logic [TICK_W-1:0]  ticks_in_step;
  } result_t;

endpackage

@@ design/css_apb_regs.sv @@
// Configuration registers of the chaser step sequencer behind an APB-style port.
// Uses css_pkg for the register map and the configuration struct.
module css_apb_regs
  import css_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic             wr_en;
  logic [REG_W-1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_count     <= COUNT_W'(1);
      cfg.hold_ticks     <= '0;
      cfg.run_order      <= ORDER_LOOP;
      cfg.start_backward <= 1'b0;
      cfg.auto_step      <= 1'b1;
    end else if (wr_en) begin
      case (reg_sel)
        REG_STEP_COUNT:     cfg.step_count     <= pwdata[COUNT_W-1:0];
        REG_HOLD_TICKS:     cfg.hold_ticks     <= pwdata[TICK_W-1:0];
        REG_RUN_ORDER:      cfg.run_order      <= pwdata[ORDER_W-1:0];
        REG_START_BACKWARD: cfg.start_backward <= pwdata[0];
        REG_AUTO_STEP:      cfg.auto_step      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_STEP_COUNT:     prdata = DATA_W'(cfg.step_count);
      REG_HOLD_TICKS:     prdata = DATA_W'(cfg.hold_ticks);
      REG_RUN_ORDER:      prdata = DATA_W'(cfg.run_order);
      REG_START_BACKWARD: prdata = DATA_W'(cfg.start_backward);
      REG_AUTO_STEP:      prdata = DATA_W'(cfg.auto_step);
      default:            prdata = '0;
    endcase
  end

endmodule

@@ design/css_step_core.sv @@
// Sequencer state and the single-pass next-state logic for one request.
// Uses css_pkg for operation codes, run orders and the cfg_t and result_t structs.
module css_step_core
  import css_pkg::*;
#(
  parameter int MAX_STEPS = DEFAULT_MAX_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [OP_W-1:0]    op,
  input  logic [INDEX_W-1:0] idx,
  input  cfg_t               cfg,
  output result_t            res
);

  localparam int CAP    = (MAX_STEPS < 511) ? MAX_STEPS : 511;
  localparam int STEP_W = $clog2(CAP);

  logic [STEP_W-1:0]  step_now, step_next;
  logic [TICK_W-1:0]  elapsed, elapsed_next;
  logic               dir_backward, dir_backward_next;
  logic               next_pending, next_pending_next;
  logic               prev_pending, prev_pending_next;
  logic               jump_pending, jump_pending_next;
  logic [INDEX_W-1:0] jump_target, jump_target_next;
  logic               done_flag, done_flag_next;
  logic               changed;

  logic [COUNT_W-1:0] n;
  logic [COUNT_W-1:0] n_minus1;
  logic [COUNT_W-1:0] step_ext;
  logic [COUNT_W-1:0] step_cl;
  logic               jump_ok;
  logic               adv_go;
  logic               up;
  logic [COUNT_W-1:0] adv_step;
  logic               adv_dir;
  logic               adv_fail;

  assign n        = (32'(cfg.step_count) > MAX_STEPS) ? COUNT_W'(MAX_STEPS) : cfg.step_count;
  assign n_minus1 = n - COUNT_W'(1);
  assign step_ext = COUNT_W'(step_now);
  assign step_cl  = (step_ext >= n) ? n_minus1 : step_ext;
  assign jump_ok  = jump_pending && (COUNT_W'(jump_target) < n);
  assign adv_go   = (cfg.auto_step && (elapsed >= cfg.hold_ticks)) || next_pending || prev_pending;
  assign up       = (dir_backward == prev_pending);

  always_comb begin
    adv_step = step_cl;
    adv_dir  = dir_backward;
    adv_fail = 1'b0;
    if (up && ((COUNT_W + 1)'(step_cl) + 1'b1 < (COUNT_W + 1)'(n))) begin
      adv_step = step_cl + COUNT_W'(1);
    end else if (!up && step_cl != '0) begin
      adv_step = step_cl - COUNT_W'(1);
    end else begin
      case (cfg.run_order)
        ORDER_SINGLE: begin
          if (up != dir_backward) begin
            adv_fail = 1'b1;
          end else begin
            adv_step = up ? n_minus1 : '0;
          end
        end
        ORDER_LOOP: adv_step = up ? '0 : n_minus1;
        default: begin
          if (n < COUNT_W'(2)) begin
            adv_step = '0;
          end else begin
            adv_step = up ? (n - COUNT_W'(2)) : COUNT_W'(1);
            adv_dir  = up;
          end
        end
      endcase
    end
  end

  always_comb begin
    step_next         = step_now;
    elapsed_next      = elapsed;
    dir_backward_next = dir_backward;
    next_pending_next = next_pending;
    prev_pending_next = prev_pending;
    jump_pending_next = jump_pending;
    jump_target_next  = jump_target;
    done_flag_next    = done_flag;
    changed           = 1'b0;
    case (op)
      OP_TICK: begin
        if (n != '0) begin
          step_next         = STEP_W'(step_cl);
          jump_pending_next = 1'b0;
          if (jump_ok) begin
            step_next         = STEP_W'(jump_target);
            next_pending_next = 1'b0;
            prev_pending_next = 1'b0;
            done_flag_next    = 1'b0;
            elapsed_next      = TICK_W'(1);
            changed           = 1'b1;
          end else if (done_flag) begin
            next_pending_next = 1'b0;
            prev_pending_next = 1'b0;
          end else if (elapsed == '0) begin
            elapsed_next = TICK_W'(1);
            changed      = 1'b1;
          end else if (adv_go) begin
            next_pending_next = 1'b0;
            prev_pending_next = 1'b0;
            if (adv_fail) begin
              done_flag_next = 1'b1;
            end else begin
              step_next         = STEP_W'(adv_step);
              dir_backward_next = adv_dir;
              elapsed_next      = TICK_W'(1);
              changed           = 1'b1;
            end
          end else if (elapsed != TICK_MAX) begin
            elapsed_next = elapsed + TICK_W'(1);
          end
        end
      end
      OP_NEXT: begin
        next_pending_next = 1'b1;
        prev_pending_next = 1'b0;
      end
      OP_PREV: begin
        next_pending_next = 1'b0;
        prev_pending_next = 1'b1;
      end
      OP_JUMP: begin
        if (COUNT_W'(idx) < n) begin
          jump_pending_next = 1'b1;
          jump_target_next  = idx;
          next_pending_next = 1'b0;
          prev_pending_next = 1'b0;
        end
      end
      OP_RESTART: begin
        dir_backward_next = cfg.start_backward;
        step_next         = (cfg.start_backward && n != '0) ? STEP_W'(n_minus1) : '0;
        elapsed_next      = '0;
        next_pending_next = 1'b0;
        prev_pending_next = 1'b0;
        done_flag_next    = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.current_step   = INDEX_W'(step_next);
    res.step_changed   = changed;
    res.finished       = done_flag_next || (n == '0);
    res.going_backward = dir_backward_next;
    res.ticks_in_step  = elapsed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_now     <= '0;
      elapsed      <= '0;
      dir_backward <= 1'b0;
      next_pending <= 1'b0;
      prev_pending <= 1'b0;
      jump_pending <= 1'b0;
      jump_target  <= '0;
      done_flag    <= 1'b0;
    end else if (en) begin
      step_now     <= step_next;
      elapsed      <= elapsed_next;
      dir_backward <= dir_backward_next;
      next_pending <= next_pending_next;
      prev_pending <= prev_pending_next;
      jump_pending <= jump_pending_next;
      jump_target  <= jump_target_next;
      done_flag    <= done_flag_next;
    end
  end

  a_req_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(next_pending && prev_pending))
    else $error("Next and previous requests pending together.");

  a_change_restarts_count: assert property (@(posedge clk) disable iff (rst)
    (en && changed) |-> (elapsed_next == TICK_W'(1)))
    else $error("Step change without tick count of one.");

  a_tick_clears_jump: assert property (@(posedge clk) disable iff (rst)
    (en && op == OP_TICK && n != '0) |=> !jump_pending)
    else $error("Jump still pending after a tick.");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    (en && op == OP_TICK && n != '0) |=> (COUNT_W'(step_now) < $past(n)))
    else $error("Step outside the step list after a tick.");

endmodule

@@ design/chaser_step_sequencer.sv @@
// Chaser step sequencer: a tick/request channel in, a status channel out, APB-style registers.
// Every accepted request returns exactly one status result.
// Channels: request (operation, step_index) and result (current_step, step_changed,
// finished, going_backward, ticks_in_step), each with valid and ready.
// A request is accepted when request_valid and request_ready are high at a rising edge.
// It is held in the input register and then evaluated in one pass
// against the sequencer state; the result register is loaded once it is empty or its result is taken.
// result_valid rises when the result register is loaded.
// Throughput: one request per cycle while the receiver keeps result_ready high.
// A waiting result does not stop the next request from entering the input register.
// When the receiver stalls, the result register holds its value and the input
// register holds one request; request_ready falls once both are occupied.
// Reset (rst, synchronous, active high) loads the register defaults: one step,
// hold zero, loop order, forward start, auto-step on; the sequencer sits at
// step 0 with no requests pending and both registers empty.
// Users must write registers via the APB-style port only while idle; the block does not check.
// Depends on css_pkg, css_apb_regs and css_step_core.
module chaser_step_sequencer
  import css_pkg::*;
#(
  parameter int MAX_STEPS = DEFAULT_MAX_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               request_valid,
  output logic               request_ready,
  input  logic [OP_W-1:0]    operation,
  input  logic [INDEX_W-1:0] step_index,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [INDEX_W-1:0] current_step,
  output logic               step_changed,
  output logic               finished,
  output logic               going_backward,
  output logic [TICK_W-1:0]  ticks_in_step
);

  cfg_t               cfg;
  result_t            core_res;
  result_t            res;
  logic               held_valid, held_valid_next;
  logic [OP_W-1:0]    held_op;
  logic [INDEX_W-1:0] held_idx;
  logic               result_valid_next;
  logic               advance;
  logic               take;

  css_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  css_step_core #(
    .MAX_STEPS (MAX_STEPS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .op  (held_op),
    .idx (held_idx),
    .cfg (cfg),
    .res (core_res)
  );

  assign advance       = held_valid && (!result_valid || result_ready);
  assign request_ready = !held_valid || advance;
  assign take          = request_valid && request_ready;

  always_comb begin
    held_valid_next = held_valid;
    if (take) begin
      held_valid_next = 1'b1;
    end else if (advance) begin
      held_valid_next = 1'b0;
    end
    result_valid_next = result_valid;
    if (advance) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      held_valid   <= held_valid_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_op  <= operation;
      held_idx <= step_index;
    end
    if (advance) begin
      res <= core_res;
    end
  end

  assign current_step   = res.current_step;
  assign step_changed   = res.step_changed;
  assign finished       = res.finished;
  assign going_backward = res.going_backward;
  assign ticks_in_step  = res.ticks_in_step;

  a_result_from_held: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(held_valid))
    else $error("Result appeared without a held request.");

endmodule
